// ===== sv/gf2_window_parity_codec_defines.svh =====
// ----------------------------------------------------------------------------
// gf2_window_parity_codec assertion macros
// Clocked assertion shorthands used by the codec top level.
// ----------------------------------------------------------------------------
`ifndef GF2_WINDOW_PARITY_CODEC_DEFINES_SVH
`define GF2_WINDOW_PARITY_CODEC_DEFINES_SVH

// Implication checked at every rising edge, off while reset is asserted.
`define GWPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define GWPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gwpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gwpc_pkg
// Shared types and constants of the GF(2) window parity codec.
// ----------------------------------------------------------------------------
`default_nettype none

package gwpc_pkg;

  localparam int DEGREE_W       = 6;
  localparam int MAX_DEGREE_DEF = 63;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int TDATA_W        = 8;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DECODE_MODE = 1'b0,
    REG_DEGREE      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                decode_mode;
    logic [DEGREE_W-1:0] degree;
  } cfg_t;

  typedef struct packed {
    logic out_bit;
    logic last_out;
  } res_t;

  typedef struct packed {
    logic tail_busy;
    logic res_valid;
  } core_sts_t;

endpackage

`default_nettype wire

// ===== sv/gf2_window_parity_codec.sv =====
// Results are registered in the two-entry output buffer before they appear on out_*.
// Throughput: one input bit per cycle while the output buffer has room and no tail run is busy.
// Encode end of block: d tail bits are emitted, input stalled meanwhile.
// Reset (rst_n low, synchronous): decode_mode 0, degree 1, window cleared,
// result buffer emptied.
// ----------------------------------------------------------------------------
// gf2_window_parity_codec
// Serial multiply/divide by 1+x+...+x^d over GF(2), stream in and out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf2_window_parity_codec_defines.svh"

module gf2_window_parity_codec #(
  parameter int MAX_DEGREE = gwpc_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [gwpc_pkg::TDATA_W-1:0]    in_tdata,   // [0] data_bit
  input  wire logic                            in_tlast,   // end_of_block
  input  wire logic [0:0]                      in_tuser,   // [0] tail_bit
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [gwpc_pkg::TDATA_W-1:0]    out_tdata,  // [0] out_bit
  output logic                                 out_tlast,  // last_out
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gwpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [gwpc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [gwpc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import gwpc_pkg::*;

  cfg_t      cfg;
  res_t      res;
  res_t      out_res;
  core_sts_t sts;
  logic      buf_full;
  logic      in_fire;

  assign in_fire = in_tvalid & in_tready;

  gwpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gwpc_core #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_fire      (in_fire),
    .data_bit     (in_tdata[0]),
    .end_of_block (in_tlast),
    .tail_bit     (in_tuser[0]),
    .buf_full     (buf_full),
    .in_ready     (in_tready),
    .res          (res),
    .sts          (sts)
  );

  gwpc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (sts.res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = TDATA_W'(out_res.out_bit);
  assign out_tlast = out_res.last_out;

  // a result is only produced when the buffer has room
  `GWPC_ASSERT_IMPL(a_no_overflow, clk, rst_n, sts.res_valid, !buf_full,
    "result produced while buffer full")

  // encode end of block starts the tail run
  `GWPC_ASSERT_NEXT(a_tail_start, clk, rst_n,
    in_fire && in_tlast && !cfg.decode_mode, sts.tail_busy,
    "encode end of block did not start tail")

  // no input transfer during the tail run
  `GWPC_ASSERT_IMPL(a_tail_stall, clk, rst_n, sts.tail_busy, !in_tready,
    "input accepted during tail run")

endmodule

`default_nettype wire

// ===== sv/gwpc_cfg.sv =====
// ----------------------------------------------------------------------------
// gwpc_cfg
// APB register block: decode_mode and degree.
// ----------------------------------------------------------------------------
`default_nettype none

module gwpc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gwpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [gwpc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [gwpc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output gwpc_pkg::cfg_t                       cfg
);
  import gwpc_pkg::*;

  logic                decode_mode_r, decode_mode_nxt;
  logic [DEGREE_W-1:0] degree_r, degree_nxt;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    decode_mode_nxt = decode_mode_r;
    degree_nxt      = degree_r;
    if (wr_en) begin
      unique case (idx)
        REG_DECODE_MODE: decode_mode_nxt = pwdata[0];
        REG_DEGREE:      degree_nxt      = pwdata[DEGREE_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      degree_r      <= DEGREE_W'(1);
    end else begin
      decode_mode_r <= decode_mode_nxt;
      degree_r      <= degree_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DECODE_MODE: prdata = CFG_DATA_W'(decode_mode_r);
      REG_DEGREE:      prdata = CFG_DATA_W'(degree_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.decode_mode = decode_mode_r;
  assign cfg.degree      = degree_r;

endmodule

`default_nettype wire

// ===== sv/gwpc_core.sv =====
// ----------------------------------------------------------------------------
// gwpc_core
// History window, masked parity and encode tail sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gwpc_core #(
  parameter int MAX_DEGREE = gwpc_pkg::MAX_DEGREE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  gwpc_pkg::cfg_t     cfg,
  input  wire logic          in_fire,
  input  wire logic          data_bit,
  input  wire logic          end_of_block,
  input  wire logic          tail_bit,
  input  wire logic          buf_full,
  output logic               in_ready,
  output gwpc_pkg::res_t     res,
  output gwpc_pkg::core_sts_t sts
);
  import gwpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_DEGREE + 1);

  logic [MAX_DEGREE-1:0] window_r, window_nxt;
  logic [CNT_W-1:0]      tail_left_r, tail_left_nxt;
  logic [DEGREE_W-1:0]   d_eff;
  logic [MAX_DEGREE-1:0] mask;
  logic                  par;
  logic                  tail_busy;
  logic                  res_valid;

  // degree 0 acts as 1, above the window size saturates
  always_comb begin
    if (cfg.degree == '0) begin
      d_eff = DEGREE_W'(1);
    end else if (cfg.degree > DEGREE_W'(MAX_DEGREE)) begin
      d_eff = DEGREE_W'(MAX_DEGREE);
    end else begin
      d_eff = cfg.degree;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i] = (DEGREE_W'(i) < d_eff);
    end
  end

  assign par       = ^(window_r & mask);
  assign tail_busy = (tail_left_r != '0);
  assign in_ready  = !tail_busy && !buf_full;

  always_comb begin
    window_nxt    = window_r;
    tail_left_nxt = tail_left_r;
    res_valid     = 1'b0;
    res.out_bit   = 1'b0;
    res.last_out  = 1'b0;
    if (tail_busy) begin
      if (!buf_full) begin
        res_valid     = 1'b1;
        res.out_bit   = par;
        res.last_out  = (tail_left_r == CNT_W'(1));
        tail_left_nxt = tail_left_r - CNT_W'(1);
        // last tail bit ends the block
        window_nxt    = (tail_left_r == CNT_W'(1)) ? '0 : MAX_DEGREE'({window_r, 1'b0});
      end
    end else if (in_fire) begin
      if (cfg.decode_mode) begin
        if (tail_bit) begin
          if (end_of_block) window_nxt = '0;
        end else begin
          res_valid    = 1'b1;
          res.out_bit  = data_bit ^ par;
          res.last_out = end_of_block;
          window_nxt   = end_of_block ? '0 : MAX_DEGREE'({window_r, data_bit ^ par});
        end
      end else begin
        res_valid    = 1'b1;
        res.out_bit  = data_bit ^ par;
        res.last_out = 1'b0;
        window_nxt   = MAX_DEGREE'({window_r, data_bit});
        if (end_of_block) tail_left_nxt = CNT_W'(d_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= '0;
      tail_left_r <= '0;
    end else begin
      window_r    <= window_nxt;
      tail_left_r <= tail_left_nxt;
    end
  end

  assign sts.tail_busy = tail_busy;
  assign sts.res_valid = res_valid;

endmodule

`default_nettype wire

// ===== sv/gwpc_obuf.sv =====
// ----------------------------------------------------------------------------
// gwpc_obuf
// Two-entry result buffer; full flag is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gwpc_obuf (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  gwpc_pkg::res_t push_res,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_ready,
  output gwpc_pkg::res_t out_res
);
  import gwpc_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & out_ready;
  assign out_res   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_res;
  end

endmodule

`default_nettype wire
